[sv/rrts_pkg.sv]
`default_nettype none

package rrts_pkg;

    localparam int unsigned NUM_TASKS_DEF = 16;

    localparam int unsigned ID_W     = 4;
    localparam int unsigned ID_NUM   = 2 ** ID_W;
    localparam int unsigned ACT_W    = 3;
    localparam int unsigned PRIO_W   = 8;
    localparam int unsigned ERR_W    = 2;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned EL_W     = 32;

    localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_YIELD  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PARK   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_UNPARK = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CREATE = 3'd4;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] priority_req;
    } t_sched_in;

    typedef struct packed {
        logic [ID_W-1:0]  running_task;
        logic             running_valid;
        logic             switched;
        logic [ERR_W-1:0] error;
        logic [CNT_W-1:0] ready_count;
        logic [EL_W-1:0]  running_elapsed;
        logic [EL_W-1:0]  tick_count;
    } t_sched_out;

endpackage

`default_nettype wire

[sv/round_robin_timeslice_scheduler_unit.sv]
// path: an input beat is taken in S_IDLE and goes through the reads of the task table
// and ready queue memories that its action needs (a tick that switches tasks takes the
// longest); the result beat is registered in S_DONE, and input is stalled until then
// reset: synchronous, active low; afterwards a clearing pass writes every task table
// entry, with input stalled; the config port is open throughout
`default_nettype none

module round_robin_timeslice_scheduler_unit
    import rrts_pkg::*;
#(
    parameter int unsigned NUM_TASKS = NUM_TASKS_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_stall,
    input  t_sched_in       i_in_data,
    output logic            o_out_valid,
    input  wire             i_out_stall,
    output t_sched_out      o_out_data,
    input  wire             i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire [ID_W-1:0]  i_cfg_data
);

    localparam int unsigned TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int unsigned CW = $clog2(NUM_TASKS + 1);

    typedef enum logic [1:0] {
        ST_BLOCKED,
        ST_READY,
        ST_RUNNING
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [PRIO_W-1:0] prio;
        logic [PRIO_W-1:0] slice;
        logic [EL_W-1:0]   elapsed;
    } t_task_ent;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RD_CUR,
        S_RD_TID,
        S_DISP,
        S_IDLE_CHK,
        S_POP,
        S_RD_NXT,
        S_DONE
    } t_state;

    function automatic logic [TW-1:0] ptr_inc(input logic [TW-1:0] p);
        logic [TW-1:0] q;
        q = (p == TW'(NUM_TASKS - 1)) ? '0 : TW'(p + 1'b1);
        return q;
    endfunction

    t_state             r_state;
    logic [TW-1:0]      r_clr_addr;
    logic [ACT_W-1:0]   r_act;
    logic [TW-1:0]      r_tid;
    logic [PRIO_W-1:0]  r_prio;
    logic [TW-1:0]      r_cur;
    logic               r_cur_v;
    logic [EL_W-1:0]    r_cur_el;
    logic [EL_W-1:0]    r_ticks;
    logic [ID_W-1:0]    r_idle;
    logic [TW-1:0]      r_head;
    logic [TW-1:0]      r_tail;
    logic [CW-1:0]      r_cnt;
    logic [TW-1:0]      r_nxt;
    logic               r_sw;
    logic [ERR_W-1:0]   r_err;
    logic               r_out_v;
    t_sched_out         r_out;

    t_task_ent          r_task_mem [NUM_TASKS];
    t_task_ent          r_tm_rd;
    logic [TW-1:0]      r_fifo_mem [NUM_TASKS];
    logic [TW-1:0]      r_fq_rd;

    logic [TW-1:0]      mod_tab [ID_NUM];
    logic [TW-1:0]      in_tid;
    logic [TW-1:0]      idle_id;
    logic               q_full;

    logic               tm_we;
    logic [TW-1:0]      tm_wa;
    t_task_ent          tm_wd;
    logic [TW-1:0]      tm_ra;
    logic               push_req;
    logic               fq_we;
    logic [TW-1:0]      fq_wd;

    for (genvar g = 0; g < ID_NUM; g++) begin : g_mod
        localparam int unsigned MV = g % NUM_TASKS;
        assign mod_tab[g] = TW'(MV);
    end

    assign in_tid  = mod_tab[i_in_data.task_id];
    assign idle_id = mod_tab[r_idle];
    assign q_full  = (r_cnt == CW'(NUM_TASKS));

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    always_comb begin
        tm_we    = 1'b0;
        tm_wa    = r_tid;
        tm_wd    = r_tm_rd;
        tm_ra    = r_cur;
        push_req = 1'b0;
        fq_wd    = r_tid;
        unique case (r_state)
            S_CLR: begin
                tm_we = 1'b1;
                tm_wa = r_clr_addr;
                tm_wd = '0;
            end
            S_IDLE: begin
                if (i_in_data.action == ACT_UNPARK || i_in_data.action == ACT_CREATE) begin
                    tm_ra = in_tid;
                end
            end
            S_RD_CUR: begin
                tm_wa = r_cur;
                fq_wd = r_cur;
                unique case (r_act)
                    ACT_TICK: begin
                        tm_we         = 1'b1;
                        tm_wd.elapsed = r_tm_rd.elapsed + 1'b1;
                        if (r_tm_rd.slice != '0) begin
                            tm_wd.slice = r_tm_rd.slice - 1'b1;
                        end else begin
                            tm_wd.slice  = r_tm_rd.prio;
                            tm_wd.status = q_full ? ST_BLOCKED : ST_READY;
                            push_req     = 1'b1;
                        end
                    end
                    ACT_YIELD: begin
                        tm_we        = 1'b1;
                        tm_wd.status = q_full ? ST_BLOCKED : ST_READY;
                        push_req     = 1'b1;
                    end
                    ACT_PARK: begin
                        tm_we        = 1'b1;
                        tm_wd.status = ST_BLOCKED;
                    end
                    default: begin
                    end
                endcase
            end
            S_RD_TID: begin
                unique case (r_act)
                    ACT_UNPARK: begin
                        if (r_tm_rd.status == ST_BLOCKED) begin
                            push_req     = 1'b1;
                            tm_we        = !q_full;
                            tm_wd.status = ST_READY;
                        end
                    end
                    ACT_CREATE: begin
                        tm_we         = 1'b1;
                        tm_wd.prio    = r_prio;
                        tm_wd.slice   = r_prio;
                        tm_wd.elapsed = '0;
                        if (r_tm_rd.status == ST_BLOCKED) begin
                            push_req     = 1'b1;
                            tm_wd.status = q_full ? ST_BLOCKED : ST_READY;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DISP: begin
                tm_ra = idle_id;
            end
            S_IDLE_CHK: begin
                tm_wa = idle_id;
                if (r_tm_rd.status == ST_BLOCKED) begin
                    tm_we        = 1'b1;
                    tm_wd.status = ST_RUNNING;
                end
            end
            S_POP: begin
                tm_ra = r_fq_rd;
            end
            S_RD_NXT: begin
                tm_we        = 1'b1;
                tm_wa        = r_nxt;
                tm_wd.status = ST_RUNNING;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
        fq_we = push_req && !q_full;
    end

    always_ff @(posedge i_clk) begin
        if (tm_we) begin
            r_task_mem[tm_wa] <= tm_wd;
        end
        r_tm_rd <= r_task_mem[tm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fq_we) begin
            r_fifo_mem[r_tail] <= fq_wd;
        end
        r_fq_rd <= r_fifo_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_cur      <= '0;
            r_cur_v    <= 1'b0;
            r_cur_el   <= '0;
            r_ticks    <= '0;
            r_idle     <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_cnt      <= '0;
            r_sw       <= 1'b0;
            r_err      <= ERR_OK;
            r_out_v    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_idle <= i_cfg_data;
            end
            if (r_out_v && !i_out_stall && r_state != S_DONE) begin
                r_out_v <= 1'b0;
            end
            if (fq_we) begin
                r_tail <= ptr_inc(r_tail);
                r_cnt  <= r_cnt + 1'b1;
            end
            if (push_req && q_full) begin
                r_err <= ERR_FULL;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= ptr_inc(r_clr_addr);
                    if (r_clr_addr == TW'(NUM_TASKS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_act  <= i_in_data.action;
                        r_tid  <= in_tid;
                        r_prio <= i_in_data.priority_req;
                        r_sw   <= 1'b0;
                        r_err  <= ERR_OK;
                        unique case (i_in_data.action)
                            ACT_TICK, ACT_YIELD, ACT_PARK: begin
                                if (i_in_data.action == ACT_TICK) begin
                                    r_ticks <= r_ticks + 1'b1;
                                end
                                r_state <= r_cur_v ? S_RD_CUR : S_DISP;
                            end
                            ACT_UNPARK, ACT_CREATE: begin
                                r_state <= S_RD_TID;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD_CUR: begin
                    if (r_act == ACT_TICK && r_tm_rd.slice != '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DISP;
                    end
                    if (r_act == ACT_TICK) begin
                        r_cur_el <= r_tm_rd.elapsed + 1'b1;
                    end
                    if (r_act == ACT_PARK) begin
                        r_cur_v <= 1'b0;
                    end
                end
                S_RD_TID: begin
                    if (r_act == ACT_CREATE && r_cur_v && r_tid == r_cur) begin
                        r_cur_el <= '0;
                    end
                    r_state <= S_DONE;
                end
                S_DISP: begin
                    r_state <= (r_cnt == '0) ? S_IDLE_CHK : S_POP;
                end
                S_IDLE_CHK: begin
                    if (r_tm_rd.status == ST_BLOCKED) begin
                        r_head   <= ptr_inc(r_head);
                        r_tail   <= ptr_inc(r_tail);
                        r_cur    <= idle_id;
                        r_cur_v  <= 1'b1;
                        r_cur_el <= r_tm_rd.elapsed;
                        r_sw     <= 1'b1;
                    end else begin
                        r_cur   <= '0;
                        r_cur_v <= 1'b0;
                        r_err   <= ERR_EMPTY;
                    end
                    r_state <= S_DONE;
                end
                S_POP: begin
                    r_nxt   <= r_fq_rd;
                    r_head  <= ptr_inc(r_head);
                    r_cnt   <= r_cnt - 1'b1;
                    r_state <= S_RD_NXT;
                end
                S_RD_NXT: begin
                    r_cur    <= r_nxt;
                    r_cur_v  <= 1'b1;
                    r_cur_el <= r_tm_rd.elapsed;
                    r_sw     <= 1'b1;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_v || !i_out_stall) begin
                        r_out_v                   <= 1'b1;
                        r_out.running_task        <= r_cur_v ? ID_W'(r_cur) : '0;
                        r_out.running_valid       <= r_cur_v;
                        r_out.switched            <= r_sw;
                        r_out.error               <= r_err;
                        r_out.ready_count         <= CNT_W'(r_cnt);
                        r_out.running_elapsed     <= r_cur_v ? r_cur_el : '0;
                        r_out.tick_count          <= r_ticks;
                        r_state                   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/rrts_chk.sv]
`default_nettype none

module rrts_chk
    import rrts_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_stall,
    input t_sched_in  i_in_data,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input t_sched_out o_out_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while previous item in flight");

    // no running task shows zeros
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.running_valid |->
            o_out_data.running_task == '0 && o_out_data.running_elapsed == '0)
        else $error("stale running task fields");

    // a dispatch leaves a task running, an empty dispatch leaves none
    a_switch_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.switched || o_out_data.error == ERR_EMPTY) |->
            o_out_data.running_valid == o_out_data.switched)
        else $error("switch flag disagrees with running state");

endmodule

bind round_robin_timeslice_scheduler_unit rrts_chk u_rrts_chk (.*);

`default_nettype wire
